[hw/rtl/itp_pkg.sv]
package itp_pkg;

  localparam int STACK_DEPTH_DEFAULT = 32;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_OPEN = 3'd1,
    OP_ADD  = 3'd2,
    OP_SUB  = 3'd3,
    OP_MUL  = 3'd4,
    OP_DIV  = 3'd5,
    OP_POW  = 3'd6
  } op_code_t;

  typedef enum logic [2:0] {
    TK_ALNUM  = 3'd0,
    TK_OPEN   = 3'd1,
    TK_CLOSE  = 3'd2,
    TK_OPER   = 3'd3,
    TK_END    = 3'd4,
    TK_IGNORE = 3'd5
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    op_code_t   code;
    logic [7:0] ch;
  } tok_t;

  typedef struct packed {
    tok_t head;
    logic avail;
  } q_head_t;

  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] c;
    case (code)
      OP_OPEN: c = CH_OPEN;
      OP_ADD:  c = CH_ADD;
      OP_SUB:  c = CH_SUB;
      OP_MUL:  c = CH_MUL;
      OP_DIV:  c = CH_DIV;
      OP_POW:  c = CH_POW;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] prec(input op_code_t code);
    logic [1:0] p;
    case (code)
      OP_POW:         p = 2'd3;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_ADD, OP_SUB: p = 2'd1;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic tok_t classify(input logic command, input logic [7:0] ch);
    tok_t t;
    t.ch   = ch;
    t.code = OP_NONE;
    t.kind = TK_IGNORE;
    if (command) begin
      t.kind = TK_END;
    end else if ((ch >= 8'h30 && ch <= 8'h39) || (ch >= 8'h41 && ch <= 8'h5A) ||
                 (ch >= 8'h61 && ch <= 8'h7A)) begin
      t.kind = TK_ALNUM;
    end else begin
      case (ch)
        CH_OPEN: begin
          t.kind = TK_OPEN;
          t.code = OP_OPEN;
        end
        CH_CLOSE: t.kind = TK_CLOSE;
        CH_ADD: begin
          t.kind = TK_OPER;
          t.code = OP_ADD;
        end
        CH_SUB: begin
          t.kind = TK_OPER;
          t.code = OP_SUB;
        end
        CH_MUL: begin
          t.kind = TK_OPER;
          t.code = OP_MUL;
        end
        CH_DIV: begin
          t.kind = TK_OPER;
          t.code = OP_DIV;
        end
        CH_POW: begin
          t.kind = TK_OPER;
          t.code = OP_POW;
        end
        default: t.kind = TK_IGNORE;
      endcase
    end
    return t;
  endfunction

endpackage

[hw/rtl/itp_front.sv]
module itp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                command,
  input  logic [7:0]          char_code,
  output itp_pkg::q_head_t    q_out,
  input  logic                q_deq
);

  itp_pkg::tok_t q_mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  itp_pkg::tok_t tok;
  logic          enq;
  logic          deq;

  assign tok        = itp_pkg::classify(command, char_code);
  assign item_stall = (fill == 2'd2);
  assign enq        = item_valid && !item_stall && (tok.kind != itp_pkg::TK_IGNORE);
  assign deq        = q_deq && (fill != 2'd0);

  assign q_out.head  = q_mem[rd_ptr];
  assign q_out.avail = (fill != 2'd0);

  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr] <= tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (deq) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({enq, deq})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hw/rtl/itp_back.sv]
module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  itp_pkg::q_head_t q_in,
  output logic             q_deq,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic             expr_done,
  output logic             overflow_seen,
  output logic             last
);

  localparam int CW          = $clog2(STACK_DEPTH + 1);
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int MEM_ENTRIES = 1 << AW;

  itp_pkg::op_code_t mem [MEM_ENTRIES];
  itp_pkg::op_code_t top;
  itp_pkg::op_code_t second;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              ovf;
  logic              ovf_next;

  logic              has_top;
  logic              has_second;
  logic              out_free;
  logic              push;
  logic              pop;
  itp_pkg::op_code_t push_code;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr_top;
  logic [AW-1:0]     raddr_sec;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;

  logic              emit;
  logic [7:0]        e_char;
  logic              e_cval;
  logic              e_done;
  logic              e_ovf;
  logic              e_last;

  itp_pkg::tok_t     head;

  assign head       = q_in.head;
  assign has_top    = (count != '0);
  assign has_second = (count > CW'(1));
  assign out_free   = !result_valid || !result_stall;

  always_comb begin
    q_deq     = 1'b0;
    push      = 1'b0;
    pop       = 1'b0;
    push_code = itp_pkg::OP_NONE;
    emit      = 1'b0;
    e_char    = itp_pkg::CH_NUL;
    e_cval    = 1'b0;
    e_done    = 1'b0;
    e_ovf     = 1'b0;
    e_last    = 1'b0;
    ovf_next  = ovf;
    if (q_in.avail) begin
      case (head.kind)
        itp_pkg::TK_ALNUM: begin
          if (out_free) begin
            emit   = 1'b1;
            e_char = head.ch;
            e_cval = 1'b1;
            e_last = 1'b1;
            q_deq  = 1'b1;
          end
        end
        itp_pkg::TK_OPEN: begin
          push      = 1'b1;
          push_code = itp_pkg::OP_OPEN;
          q_deq     = 1'b1;
        end
        itp_pkg::TK_CLOSE: begin
          if (has_top && top != itp_pkg::OP_OPEN) begin
            if (out_free) begin
              emit   = 1'b1;
              e_char = itp_pkg::code_char(top);
              e_cval = 1'b1;
              e_last = !has_second || (second == itp_pkg::OP_OPEN);
              pop    = 1'b1;
            end
          end else begin
            pop   = has_top;
            q_deq = 1'b1;
          end
        end
        itp_pkg::TK_OPER: begin
          if (has_top && top != itp_pkg::OP_OPEN &&
              itp_pkg::prec(top) >= itp_pkg::prec(head.code)) begin
            if (out_free) begin
              emit   = 1'b1;
              e_char = itp_pkg::code_char(top);
              e_cval = 1'b1;
              e_last = !(has_second && second != itp_pkg::OP_OPEN &&
                         itp_pkg::prec(second) >= itp_pkg::prec(head.code));
              pop    = 1'b1;
            end
          end else begin
            push      = 1'b1;
            push_code = head.code;
            q_deq     = 1'b1;
          end
        end
        itp_pkg::TK_END: begin
          if (has_top) begin
            if (top == itp_pkg::OP_OPEN) begin
              pop = 1'b1;
            end else if (out_free) begin
              emit   = 1'b1;
              e_char = itp_pkg::code_char(top);
              e_cval = 1'b1;
              pop    = 1'b1;
            end
          end else if (out_free) begin
            emit     = 1'b1;
            e_done   = 1'b1;
            e_ovf    = ovf;
            e_last   = 1'b1;
            ovf_next = 1'b0;
            q_deq    = 1'b1;
          end
        end
        default: q_deq = 1'b1;
      endcase
    end
    we = push && (count < CW'(STACK_DEPTH));
    if (push && !we) begin
      ovf_next = 1'b1;
    end
  end

  always_comb begin
    count_next = count;
    if (we) begin
      count_next = count + CW'(1);
    end else if (pop) begin
      count_next = count - CW'(1);
    end
  end

  assign cnt_m1    = count_next - CW'(1);
  assign cnt_m2    = count_next - CW'(2);
  assign raddr_top = cnt_m1[AW-1:0];
  assign raddr_sec = cnt_m2[AW-1:0];
  assign waddr     = count[AW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= push_code;
    end
    if (we && waddr == raddr_top) begin
      top <= push_code;
    end else begin
      top <= mem[raddr_top];
    end
    second <= mem[raddr_sec];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      count <= count_next;
      ovf   <= ovf_next;
      if (emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char      <= e_char;
      char_valid    <= e_cval;
      expr_done     <= e_done;
      overflow_seen <= e_ovf;
      last          <= e_last;
    end
  end

endmodule

[hw/rtl/infix_to_postfix_converter_core.sv]
// Streaming infix to postfix converter using an operator stack.
// Input channel: item_valid, item_stall, command and char_code. One beat
// carries one ASCII character, or an end command when command is high.
// Letters and digits pass straight through; operators and '(' are
// held on the stack and released by precedence; other characters are dropped.
// Output channel: result_valid, result_stall and the result fields. Each
// beat carries one postfix character or, after an end command, one
// terminating beat with expr_done and the sticky overflow flag; last marks
// the final beat caused by an input beat.
// An accepted beat passes the queue and then the output register before its
// first result appears. The stack engine handles each letter or digit, each
// popped operator, each discarded '(', each push and the terminating beat as
// a separate step. A beat pops its stack entries one by one and then finishes,
// except that ')' finishes in the same cycle that drops its '('.
// A two-entry queue separates the classifier from the stack engine, so up to
// two beats are taken while the engine waits on result_stall; item_stall then
// stays high until the engine frees an entry. Dropped characters never enter
// the queue. A stalled result beat stays unchanged until it is taken.
// Reset empties the stack, the queue and the output register and clears the
// overflow flag.
module infix_to_postfix_converter_core #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic       command,
  input  logic [7:0] char_code,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] out_char,
  output logic       char_valid,
  output logic       expr_done,
  output logic       overflow_seen,
  output logic       last
);

  itp_pkg::q_head_t q_head;
  logic             q_deq;

  itp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .command    (command),
    .char_code  (char_code),
    .q_out      (q_head),
    .q_deq      (q_deq)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_in          (q_head),
    .q_deq         (q_deq),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .out_char      (out_char),
    .char_valid    (char_valid),
    .expr_done     (expr_done),
    .overflow_seen (overflow_seen),
    .last          (last)
  );

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && expr_done |-> last && !char_valid)
    else $error("Terminating beat is not marked last or carries a character.");

  a_char_or_done: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (char_valid != expr_done))
    else $error("Result beat is neither a character nor a terminator.");

  a_term_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !char_valid |-> out_char == 8'h00)
    else $error("Terminating beat carries a non-zero character.");

  a_ovf_only_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflow_seen |-> expr_done)
    else $error("Overflow reported on a character beat.");

endmodule
